### design/nsp_pkg.sv
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared types, codes and widths of the nested section profiler.
// ----------------------------------------------------------------------------
package nsp_pkg;

    localparam int NODE_COUNT_DEF  = 64;
    localparam int STACK_DEPTH_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int TS_W     = 64;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int LEVEL_W  = 5;
    localparam int CALL_W   = 32;
    localparam int REC_W    = 32;

    localparam int S_TDATA_W = 96;   // key + timestamp
    localparam int M_TDATA_W = 144;  // 139 payload bits, padded to bytes

    localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STS_TABLE_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_STACK_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_END_AT_ROOT = 3'd3;
    localparam logic [STATUS_W-1:0] STS_BAD_KEY     = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_BEG_RD,
        S_BEG_UPD,
        S_END_UPD,
        S_TOP_LD,
        S_CLR,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [TS_W-1:0]   ticks;
        logic [CALL_W-1:0] calls;
    } t_node_rec;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [LEVEL_W-1:0]  level;
        logic [TS_W-1:0]     ticks;
        logic [CALL_W-1:0]   calls;
        logic [REC_W-1:0]    rec;
    } t_result;

endpackage

### design/nsp_ram.sv
// ----------------------------------------------------------------------------
// nsp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nsp_ram import nsp_pkg::*; #(
    parameter int WIDTH = KEY_W,
    parameter int DEPTH = NODE_COUNT_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/nested_section_profiler_core.sv
// ----------------------------------------------------------------------------
// nested_section_profiler_core
// Section profiler: key table, per-node totals and a frame stack in RAM.
// ----------------------------------------------------------------------------
// One transaction in flight: a new one is accepted only in idle, after the result has been
// loaded into the output register (held while it is full).
// Begin: dispatch, key table scan (one key read a cycle), node read, update, emit.
// End: dispatch, update, a top reload when a pop exposes a frame, emit. Bad key, end at
// root, unused command: dispatch, emit. Clear: node totals zeroed one entry per cycle.
// Reset is synchronous; key table and stack start empty, no clearing pass.
module nested_section_profiler_core import nsp_pkg::*; #(
    parameter int NODE_COUNT  = NODE_COUNT_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // section_key[31:0], timestamp[95:32]
    input  logic [CMD_W-1:0]     i_s_tuser,  // command[1:0]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // node_slot[5:0], stack_level[10:6], total_ticks[74:11], call_count[106:75],
    // recursion_level[138:107], zero pad[143:139]
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [STATUS_W-1:0]  o_m_tuser   // status[2:0]
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int FW = $clog2(NODE_COUNT + 1);
    localparam int TW = $clog2(STACK_DEPTH);

    typedef struct packed {
        logic [NW-1:0]    node;
        logic [REC_W-1:0] rec;
        logic [TS_W-1:0]  start;
    } t_frame;

    localparam int FRAME_W = $bits(t_frame);
    localparam int NREC_W  = $bits(t_node_rec);

    t_state r_state, n_state;
    logic [TW-1:0]  r_top, n_top;
    logic [FW-1:0]  r_fill, n_fill;
    logic [FW-1:0]  r_rd_idx, n_rd_idx;
    logic           r_cmp_vld, n_cmp_vld;
    logic [NW-1:0]  r_cmp_idx, n_cmp_idx;
    logic [NW-1:0]  r_slot, n_slot;
    logic           r_out_vld, n_out_vld;
    t_result        r_res, n_res;
    t_result        r_out, n_out;
    logic [CMD_W-1:0] r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [TS_W-1:0]  r_ts;

    // ram ports
    logic              key_we, key_re;
    logic [NW-1:0]     key_waddr;
    logic [KEY_W-1:0]  key_q;
    logic              node_we, node_re;
    logic [NW-1:0]     node_waddr, node_raddr;
    t_node_rec         node_wdata, node_q;
    logic              stk_we, stk_re;
    logic [TW-1:0]     stk_waddr, stk_raddr;
    t_frame            stk_wdata, stk_q;

    logic              in_acc, out_free;
    logic [REC_W-1:0]  cur_rec;
    logic              scan_more, scan_hit, scan_miss, tbl_full, stk_full, recur;
    logic              pop, clr_done;

    nsp_ram #(.WIDTH(KEY_W), .DEPTH(NODE_COUNT)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (r_key),
        .i_re    (key_re),
        .i_raddr (r_rd_idx[NW-1:0]),
        .o_rdata (key_q)
    );

    nsp_ram #(.WIDTH(NREC_W), .DEPTH(NODE_COUNT)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (node_re),
        .i_raddr (node_raddr),
        .o_rdata (node_q)
    );

    nsp_ram #(.WIDTH(FRAME_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_q)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_vld || i_m_tready;

    // the root frame never carries recursion
    assign cur_rec   = (r_top == '0) ? '0 : stk_q.rec;
    assign scan_more = (r_rd_idx < r_fill);
    assign scan_hit  = r_cmp_vld && (key_q == r_key);
    assign scan_miss = !r_cmp_vld && (r_rd_idx == r_fill);
    assign tbl_full  = (r_fill == FW'(NODE_COUNT));
    assign stk_full  = (r_top == TW'(STACK_DEPTH - 1));
    assign recur     = (r_top != '0) && (stk_q.node == r_slot);
    assign pop       = (stk_q.rec == '0);
    assign clr_done  = (r_rd_idx == r_fill);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_LOOK;
            end
            S_LOOK: begin
                case (r_cmd)
                    CMD_BEGIN: n_state = (r_key == '0) ? S_EMIT : S_SCAN;
                    CMD_END:   n_state = (r_top == '0) ? S_EMIT : S_END_UPD;
                    CMD_CLEAR: n_state = S_CLR;
                    default:   n_state = S_EMIT;
                endcase
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = S_BEG_RD;
                end else if (scan_miss) begin
                    n_state = tbl_full ? S_EMIT : S_BEG_RD;
                end
            end
            S_BEG_RD:  n_state = S_BEG_UPD;
            S_BEG_UPD: n_state = S_EMIT;
            S_END_UPD: n_state = (pop && r_top != TW'(1)) ? S_TOP_LD : S_EMIT;
            S_TOP_LD:  n_state = S_EMIT;
            S_CLR: begin
                if (clr_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_top      = r_top;
        n_fill     = r_fill;
        n_rd_idx   = r_rd_idx;
        n_cmp_vld  = 1'b0;
        n_cmp_idx  = r_cmp_idx;
        n_slot     = r_slot;
        n_res      = r_res;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !i_m_tready;
        key_we     = 1'b0;
        key_re     = 1'b0;
        key_waddr  = r_fill[NW-1:0];
        node_we    = 1'b0;
        node_re    = 1'b0;
        node_waddr = r_slot;
        node_raddr = r_slot;
        node_wdata = '0;
        stk_we     = 1'b0;
        stk_re     = 1'b0;
        stk_waddr  = r_top;
        stk_raddr  = r_top;
        stk_wdata  = stk_q;

        unique case (r_state)
            S_IDLE: begin
                n_rd_idx = '0;
                stk_re   = in_acc;
            end
            S_LOOK: begin
                n_res = '{status: STS_OK, slot: '0, level: LEVEL_W'(r_top),
                          ticks: '0, calls: '0, rec: cur_rec};
                case (r_cmd)
                    CMD_BEGIN: begin
                        if (r_key == '0) n_res.status = STS_BAD_KEY;
                    end
                    CMD_END: begin
                        if (r_top == '0) begin
                            n_res.status = STS_END_AT_ROOT;
                        end else begin
                            node_re    = 1'b1;
                            node_raddr = stk_q.node;
                        end
                    end
                    CMD_CLEAR: begin
                        n_top     = '0;
                        n_res.level = '0;
                        n_res.rec   = '0;
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                // pipelined scan: read issued one cycle, compared the next
                key_re    = scan_more && !scan_hit;
                n_cmp_vld = key_re;
                n_cmp_idx = r_rd_idx[NW-1:0];
                if (key_re) n_rd_idx = r_rd_idx + FW'(1);
                if (scan_hit) begin
                    n_slot = r_cmp_idx;
                end else if (scan_miss) begin
                    if (tbl_full) begin
                        n_res.status = STS_TABLE_FULL;
                    end else begin
                        key_we     = 1'b1;
                        node_we    = 1'b1;
                        node_waddr = r_fill[NW-1:0];
                        n_slot     = r_fill[NW-1:0];
                        n_fill     = r_fill + FW'(1);
                    end
                end
            end
            S_BEG_RD: begin
                node_re = 1'b1;
            end
            S_BEG_UPD: begin
                n_res.slot  = SLOT_W'(r_slot);
                n_res.ticks = node_q.ticks;
                n_res.calls = node_q.calls;
                if (stk_full) begin
                    n_res.status = STS_STACK_FULL;
                end else if (recur) begin
                    stk_we        = 1'b1;
                    stk_wdata.rec = stk_q.rec + REC_W'(1);
                    n_res.rec     = stk_q.rec + REC_W'(1);
                end else begin
                    n_top     = r_top + TW'(1);
                    stk_we    = 1'b1;
                    stk_waddr = r_top + TW'(1);
                    stk_wdata = '{node: r_slot, rec: '0, start: r_ts};
                    n_res.level = LEVEL_W'(r_top + TW'(1));
                    n_res.rec   = '0;
                end
            end
            S_END_UPD: begin
                node_we          = 1'b1;
                node_waddr       = stk_q.node;
                node_wdata.calls = node_q.calls + CALL_W'(1);
                node_wdata.ticks = node_q.ticks;
                if (pop) begin
                    node_wdata.ticks = node_q.ticks + (r_ts - stk_q.start);
                    n_top     = r_top - TW'(1);
                    stk_re    = 1'b1;
                    stk_raddr = r_top - TW'(1);
                    n_res.rec = '0;
                end else begin
                    stk_we        = 1'b1;
                    stk_wdata.rec = stk_q.rec - REC_W'(1);
                    n_res.rec     = stk_q.rec - REC_W'(1);
                end
                n_res.slot  = SLOT_W'(stk_q.node);
                n_res.level = LEVEL_W'(n_top);
                n_res.ticks = node_wdata.ticks;
                n_res.calls = node_wdata.calls;
            end
            S_TOP_LD: begin
                n_res.rec = stk_q.rec;
            end
            S_CLR: begin
                if (!clr_done) begin
                    node_we    = 1'b1;
                    node_waddr = r_rd_idx[NW-1:0];
                    n_rd_idx   = r_rd_idx + FW'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_top     <= '0;
            r_fill    <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_top     <= n_top;
            r_fill    <= n_fill;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_slot    <= n_slot;
        r_res     <= n_res;
        r_out     <= n_out;
        if (in_acc) begin
            r_cmd <= i_s_tuser;
            r_key <= i_s_tdata[KEY_W-1:0];
            r_ts  <= i_s_tdata[KEY_W+TS_W-1:KEY_W];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {5'b0, r_out.rec, r_out.calls, r_out.ticks, r_out.level, r_out.slot};

    // key table never grows past its size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(NODE_COUNT))
        else $error("key table fill beyond node count");

    // a scan hit is always inside the filled part of the table
    a_hit_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_hit |-> (FW'(r_cmp_idx) < r_fill))
        else $error("key match outside filled slots");

    // a push raises the stack top by exactly one
    a_push_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BEG_UPD && !stk_full && !recur) |=> (r_top == $past(r_top) + TW'(1)))
        else $error("push did not advance stack top");

    // an accepted transaction always starts with the dispatch step
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_LOOK))
        else $error("accepted transaction not dispatched");

endmodule

### sim/nested_section_profiler_core_tb.sv
// ----------------------------------------------------------------------------
// nested_section_profiler_core_tb
// Drives begin, end, clear and spare commands into the profiler stream and
// checks every result transaction against a cycle-free profile of the node
// table and frame stack kept here: directed corner cases first, then random
// nesting, deep stacks, a table fill and noise, with random stalls on both
// buses.
// ----------------------------------------------------------------------------
module nested_section_profiler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nsp_pkg::*;

    localparam int NODES       = NODE_COUNT_DEF;
    localparam int DEPTH       = STACK_DEPTH_DEF;
    localparam int NO_SLOT     = -1;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int ITEM_GOAL   = 950;
    localparam int POOL_N      = 24;
    localparam int LONG_HOLD   = 300;
    localparam int IDLE_LIMIT  = 3000;
    localparam int TAIL_CYCLES = 150;
    localparam int PRINT_CAP   = 50;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [TS_W-1:0]  ts;
    } prof_op_t;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 s_tvalid   = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata    = '0;  // section_key[31:0], timestamp[95:32]
    logic [CMD_W-1:0]     s_tuser    = '0;  // command[1:0]
    logic                 m_tvalid;
    logic                 m_tready   = 1'b0;
    // node_slot[5:0], stack_level[10:6], total_ticks[74:11], call_count[106:75],
    // recursion_level[138:107], zero pad[143:139]
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;          // status[2:0]

    nested_section_profiler_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // profile state: node table and frame stack
    bit [KEY_W-1:0]  slot_key   [NODES];
    bit [TS_W-1:0]   slot_ticks [NODES];
    bit [CALL_W-1:0] slot_calls [NODES];
    int              frame_slot [DEPTH];
    bit [REC_W-1:0]  frame_rec  [DEPTH];
    bit [TS_W-1:0]   frame_t0   [DEPTH];
    int              stack_top;

    prof_op_t   section_ops_q[$];
    t_result    expected_reports[$];
    bit [KEY_W-1:0] key_pool[POOL_N];
    bit [TS_W-1:0]  now_ts;
    int         items_made;
    int         mismatches;
    int         idle_cycles;
    bit         s_fire;
    bit         m_fire;
    bit         send_idle_on;
    bit         recv_idle_on;
    int         long_holds_asked;
    int         long_holds_done;
    int         send_gap;
    int         hold_left;
    int         recv_gap;
    prof_op_t   drive_op;
    prof_op_t   seen_op;
    t_result    got;
    t_result    want;

    function automatic void empty_stack();
        for (int f = 0; f < DEPTH; f++) frame_slot[f] = NO_SLOT;
        stack_top = 0;
    endfunction

    function automatic t_result profile_step(input prof_op_t op);
        t_result r;
        int      slot;
        int      node;
        r        = '0;
        r.status = STS_OK;
        slot     = NO_SLOT;
        case (op.cmd)
            CMD_BEGIN: begin
                if (op.key == '0) begin
                    r.status = STS_BAD_KEY;
                end else begin
                    // a new key claims the first empty slot before the stack check
                    for (int n = 0; n < NODES; n++) begin
                        if (slot_key[n] == op.key) begin
                            slot = n;
                            break;
                        end
                        if (slot_key[n] == '0) begin
                            slot_key[n] = op.key;
                            slot = n;
                            break;
                        end
                    end
                    if (slot == NO_SLOT) begin
                        r.status = STS_TABLE_FULL;
                    end else if (stack_top >= DEPTH - 1) begin
                        r.status = STS_STACK_FULL;
                    end else if (frame_slot[stack_top] != slot) begin
                        stack_top++;
                        frame_rec[stack_top]  = '0;
                        frame_slot[stack_top] = slot;
                        frame_t0[stack_top]   = op.ts;
                    end else begin
                        frame_rec[stack_top]++;
                    end
                end
            end
            CMD_END: begin
                if (stack_top == 0) begin
                    r.status = STS_END_AT_ROOT;
                end else begin
                    node = frame_slot[stack_top];
                    slot_calls[node]++;
                    if (frame_rec[stack_top] == '0) begin
                        slot_ticks[node] += op.ts - frame_t0[stack_top];
                        frame_slot[stack_top] = NO_SLOT;
                        stack_top--;
                    end else begin
                        frame_rec[stack_top]--;
                    end
                    slot = node;
                end
            end
            CMD_CLEAR: begin
                for (int n = 0; n < NODES; n++) begin
                    slot_ticks[n] = '0;
                    slot_calls[n] = '0;
                end
                empty_stack();
            end
            default: ;
        endcase
        r.level = stack_top[LEVEL_W-1:0];
        r.rec   = frame_rec[stack_top];
        if (slot != NO_SLOT) begin
            r.slot  = slot[SLOT_W-1:0];
            r.ticks = slot_ticks[slot];
            r.calls = slot_calls[slot];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        // keep the log short when the block is badly broken
        if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit [TS_W-1:0] next_ts();
        if ($urandom_range(0, 24) == 0) now_ts = {$urandom, $urandom};
        else now_ts += $urandom_range(1, 2000);
        return now_ts;
    endfunction

    function automatic void push_op_at(input logic [CMD_W-1:0] cmd,
                                       input logic [KEY_W-1:0] key,
                                       input logic [TS_W-1:0] ts);
        prof_op_t op;
        op.cmd = cmd;
        op.key = key;
        op.ts  = ts;
        section_ops_q.push_back(op);
        if (cmd != CMD_SPARE) items_made++;
    endfunction

    function automatic void push_op(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
        push_op_at(cmd, key, next_ts());
    endfunction

    function automatic bit [KEY_W-1:0] fresh_key();
        bit [KEY_W-1:0] k;
        k = $urandom;
        if (k == '0) k = 32'h0000_0001;
        return k;
    endfunction

    // well-formed nesting with random keys; a deep one runs into the full stack
    function automatic void gen_nest(input int depth, input bit deep);
        int k;
        int prev;
        prev = -1;
        for (int d = 0; d < depth; d++) begin
            if (!deep && prev >= 0 && $urandom_range(0, 3) == 0) begin
                k = prev;
            end else begin
                k = $urandom_range(0, POOL_N - 1);
                if (deep && k == prev) k = (k + 1) % POOL_N;
            end
            push_op(CMD_BEGIN, key_pool[k]);
            prev = k;
            if (!deep && $urandom_range(0, 5) == 0) push_op(CMD_END, $urandom);
        end
        // recursion attempt on a full stack
        if (deep) push_op(CMD_BEGIN, key_pool[prev]);
        for (int d = 0; d < depth + deep + $urandom_range(0, 1); d++)
            push_op(CMD_END, $urandom);
    endfunction

    function automatic void gen_noise(input int count);
        int               r;
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        for (int i = 0; i < count; i++) begin
            r   = $urandom_range(0, 99);
            cmd = (r < 50) ? CMD_BEGIN : (r < 88) ? CMD_END : (r < 94) ? CMD_CLEAR : CMD_SPARE;
            r   = $urandom_range(0, 9);
            key = (r == 0) ? '0 : (r < 3) ? fresh_key() : key_pool[$urandom_range(0, POOL_N - 1)];
            if ($urandom_range(0, 5) == 0) push_op_at(cmd, key, {$urandom, $urandom});
            else push_op(cmd, key);
        end
    endfunction

    task automatic wait_all_done();
        while (section_ops_q.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // sender
    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else if (!s_tvalid || s_fire) begin
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap--;
            end else if (section_ops_q.size() != 0) begin
                drive_op = section_ops_q.pop_front();
                s_tuser  <= drive_op.cmd;
                s_tdata  <= {drive_op.ts, drive_op.key};
                s_tvalid <= 1'b1;
                send_gap = pick_gap(send_idle_on);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (long_holds_done != long_holds_asked) begin
            m_tready <= 1'b0;
            hold_left = LONG_HOLD;
            long_holds_done++;
        end else begin
            recv_gap = pick_gap(recv_idle_on);
            m_tready <= (recv_gap == 0);
            hold_left = (recv_gap > 0) ? recv_gap - 1 : 0;
        end
    end

    // monitor: predict on input transactions, check on output transactions
    always @(posedge clk) begin
        s_fire = rst_n && s_tvalid && s_tready;
        m_fire = rst_n && m_tvalid && m_tready;
        if (s_fire) begin
            seen_op.cmd = s_tuser;
            seen_op.key = s_tdata[31:0];
            seen_op.ts  = s_tdata[95:32];
            expected_reports.push_back(profile_step(seen_op));
        end
        if (m_fire) begin
            got.status = m_tuser;
            got.slot   = m_tdata[5:0];
            got.level  = m_tdata[10:6];
            got.ticks  = m_tdata[74:11];
            got.calls  = m_tdata[106:75];
            got.rec    = m_tdata[138:107];
            if (expected_reports.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = expected_reports.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
                if (got.slot !== want.slot)
                    report_mismatch($sformatf("node_slot got %0d want %0d", got.slot, want.slot));
                if (got.level !== want.level)
                    report_mismatch($sformatf("stack_level got %0d want %0d",
                                              got.level, want.level));
                if (got.ticks !== want.ticks)
                    report_mismatch($sformatf("total_ticks got %h want %h",
                                              got.ticks, want.ticks));
                if (got.calls !== want.calls)
                    report_mismatch($sformatf("call_count got %0d want %0d",
                                              got.calls, want.calls));
                if (got.rec !== want.rec)
                    report_mismatch($sformatf("recursion_level got %0d want %0d",
                                              got.rec, want.rec));
            end
        end
        if (!rst_n || s_fire || m_fire) idle_cycles = 0;
        else idle_cycles++;
    end

    // watchdog
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int phase;
        int sel;
        empty_stack();
        key_pool[0] = 32'hFFFF_FFFF;
        for (int i = 1; i < POOL_N; i++) key_pool[i] = fresh_key();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed corner cases
        push_op_at(CMD_END, $urandom, '0);            // end at root
        push_op_at(CMD_BEGIN, '0, 64'd1);             // reserved key
        push_op_at(CMD_SPARE, '1, '1);                // unused command
        push_op_at(CMD_BEGIN, '1, '0);
        push_op_at(CMD_BEGIN, '1, 64'd5);             // recursion on top node
        push_op_at(CMD_BEGIN, 32'd1, 64'd10);
        push_op_at(CMD_END, '0, '1);
        push_op_at(CMD_END, $urandom, 64'd100);       // recursive end
        push_op_at(CMD_END, '1, '1);                  // final end, full-range elapsed
        push_op_at(CMD_END, '0, 64'd7);
        push_op_at(CMD_BEGIN, 32'h8000_0000, '1);
        push_op_at(CMD_END, $urandom, 64'd3);         // elapsed time wraps
        push_op_at(CMD_CLEAR, $urandom, 64'd9);
        push_op_at(CMD_BEGIN, 32'd1, 64'd20);         // name kept, totals zeroed
        push_op_at(CMD_BEGIN, '1, 64'd30);
        push_op_at(CMD_BEGIN, '1, 64'd31);
        push_op_at(CMD_CLEAR, '1, '0);                // clear with frames open
        push_op_at(CMD_END, $urandom, 64'd40);
        now_ts = 64'd1000;
        wait_all_done();

        phase = 0;
        while (items_made < ITEM_GOAL) begin
            while (section_ops_q.size() > 4) @(posedge clk);
            phase++;
            send_idle_on = ($urandom_range(0, 4) != 0);
            recv_idle_on = ($urandom_range(0, 4) != 0);
            if (phase == 8 || phase == 55) begin
                // receiver holds off while the sender keeps offering
                send_idle_on = 1'b0;
                long_holds_asked++;
                gen_nest(12, 1'b0);
            end else if (phase == 12 || phase == 70) begin
                gen_nest(DEPTH + 2, 1'b1);
            end else if (phase == 30) begin
                // new keys until the node table overflows
                for (int i = 0; i < NODES + 6; i++) begin
                    push_op(CMD_BEGIN, fresh_key());
                    push_op(CMD_END, $urandom);
                end
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 70) gen_nest($urandom_range(1, 8), 1'b0);
                else if (sel < 92) gen_noise($urandom_range(3, 12));
                else push_op(CMD_CLEAR, $urandom);
            end
            if (phase % 10 == 0) wait_all_done();
        end

        wait_all_done();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_reports.size() != 0) report_mismatch("expected results left over");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
design/nsp_pkg.sv
design/nsp_ram.sv
design/nested_section_profiler_core.sv
sim/nested_section_profiler_core_tb.sv
